>>> sv/opd_pkg.sv
// Shared types, constants and codes of the overlapping pulse port driver.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package opd_pkg;

   localparam int PULSE_SLOTS = 4;
   localparam int TIME_BITS   = 32;
   localparam int SLOT_BITS   = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
   localparam int CNT_BITS    = $clog2(PULSE_SLOTS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int NOW_BITS    = 32;
   localparam int DATA_BITS   = 8;
   localparam int DUR_BITS    = 31;
   localparam int PEND_BITS   = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_DURATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_ENABLE    = 2'd1;

   // item kinds, encoded as the mode field
   typedef enum logic [1:0] {
      CMD_REFRESH = 2'd0,
      CMD_PULSE   = 2'd1,
      CMD_SET     = 2'd2,
      CMD_MASK    = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [DATA_BITS-1:0]       value;
      logic [TIME_BITS-1:0]       now;
   } cmd_type;

   typedef struct packed {
      logic [DUR_BITS-1:0] pulse_duration;
      logic                port_enable;
   } cfg_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] port_value;
      logic                 port_write;
      logic [PEND_BITS-1:0] pending_pulses;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_WALK   = 2'd1,
      ST_FINISH = 2'd2
   } back_state_type;

endpackage
`default_nettype wire

>>> sv/opd_front.sv
// Front end: takes request beats, classifies the mode and holds one command.
// Depends on opd_pkg.
`default_nettype none
module opd_front import opd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [1:0]  in_mode,
   input  wire logic [DATA_BITS-1:0] in_value,
   input  wire logic [NOW_BITS-1:0]  in_now,
   output logic             cmd_valid,
   input  wire logic        cmd_ready,
   output cmd_type          cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   cmd_kind_type kind;

   always_comb begin
      case (in_mode)
         2'd0:    kind = CMD_REFRESH;
         2'd1:    kind = CMD_PULSE;
         2'd2:    kind = CMD_SET;
         2'd3:    kind = CMD_MASK;
         default: kind = CMD_REFRESH;
      endcase
   end

   assign in_ready = !valid_ff || cmd_ready;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (valid_ff && cmd_ready) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in     = 1'b1;
         cmd_in.kind  = kind;
         cmd_in.value = in_value;
         cmd_in.now   = TIME_BITS'(in_now);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule
`default_nettype wire

>>> sv/opd_queue.sv
// Short command queue between front and back end.
// Depends on opd_pkg.
`default_nettype none
module opd_queue import opd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  cmd_type   push_cmd,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output cmd_type   pop_cmd
);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_cmd    = entry_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> sv/opd_back.sv
// Back end: applies the mode; with the port enabled, walks the pulse ring
// newest first (one slot a cycle), updates the port; registers the result. Depends on opd_pkg.
`default_nettype none
module opd_back import opd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  cfg_type   cfg,
   input  wire logic cmd_valid,
   output logic      cmd_ready,
   input  cmd_type   cmd,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp
);

   function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] p);
      return (p == SLOT_BITS'(PULSE_SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SLOT_BITS-1:0] slot_dec(input logic [SLOT_BITS-1:0] p);
      return (p == '0) ? SLOT_BITS'(PULSE_SLOTS - 1) : p - 1'b1;
   endfunction

   back_state_type state_ff, state_in;

   logic [DATA_BITS-1:0] slot_bits_ff  [PULSE_SLOTS];
   logic [TIME_BITS-1:0] slot_start_ff [PULSE_SLOTS];

   logic [SLOT_BITS-1:0] head_ff, head_in, pos_ff, pos_in;
   logic [CNT_BITS-1:0]  count_ff, count_in, k_ff, k_in;
   logic [DATA_BITS-1:0] bg_ff, bg_in, last_ff, last_in, val_ff, val_in;
   logic [DATA_BITS-1:0] pend_bits_ff, pend_bits_in;
   logic                 pend_ff, pend_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 take_cmd, out_free, walk_done, slot_live;
   logic                 bits_we, start_we;
   logic [TIME_BITS-1:0] elapsed;
   logic [CNT_BITS-1:0]  count_up;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign walk_done = (k_ff == count_ff);
   assign elapsed   = now_ff - slot_start_ff[pos_ff];
   assign slot_live = (64'(elapsed) < 64'(cfg.pulse_duration));
   assign count_up  = (count_ff == CNT_BITS'(PULSE_SLOTS)) ? count_ff : count_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = cfg.port_enable ? ST_WALK : ST_FINISH;
            end
         end
         ST_WALK: begin
            if (walk_done || !slot_live) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      take_cmd     = 1'b0;
      bits_we      = 1'b0;
      start_we     = 1'b0;
      head_in      = head_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      bg_in        = bg_ff;
      last_in      = last_ff;
      val_in       = val_ff;
      pend_bits_in = pend_bits_ff;
      pend_in      = pend_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               take_cmd = 1'b1;
               now_in   = cmd.now;
               k_in     = '0;
               pos_in   = slot_dec(head_ff);
               case (cmd.kind)
                  CMD_PULSE: begin
                     bits_we      = 1'b1;
                     pend_bits_in = cmd.value;
                     pend_in      = 1'b1;
                  end
                  CMD_SET:  bg_in = bg_ff | cmd.value;
                  CMD_MASK: bg_in = bg_ff & cmd.value;
                  default:  bg_in = bg_ff;
               endcase
               val_in = pend_in ? (bg_in | pend_bits_in) : bg_in;
            end
         end
         ST_WALK: begin
            if (!walk_done) begin
               if (slot_live) begin
                  val_in = val_ff | slot_bits_ff[pos_ff];
                  k_in   = k_ff + 1'b1;
                  pos_in = slot_dec(pos_ff);
               end else begin
                  // expired: drop this pulse and every older one
                  count_in = k_ff;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (cfg.port_enable) begin
                  last_in           = val_ff;
                  rsp_in.port_value = val_ff;
                  rsp_in.port_write = (val_ff != last_ff);
                  if (pend_ff) begin
                     start_we = 1'b1;
                     head_in  = slot_inc(head_ff);
                     count_in = count_up;
                     pend_in  = 1'b0;
                  end
                  rsp_in.pending_pulses = PEND_BITS'(count_in);
               end else begin
                  rsp_in.port_value     = last_ff;
                  rsp_in.port_write     = 1'b0;
                  rsp_in.pending_pulses = '0;
               end
            end
         end
         default: begin
            take_cmd = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         bg_ff        <= '0;
         last_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         bg_ff        <= bg_in;
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      k_ff         <= k_in;
      val_ff       <= val_in;
      pend_bits_ff <= pend_bits_in;
      now_ff       <= now_in;
      rsp_ff       <= rsp_in;
      if (bits_we) begin
         slot_bits_ff[head_ff] <= cmd.value;
      end
      if (start_we) begin
         slot_start_ff[head_ff] <= now_ff;
      end
   end

   assign cmd_ready = take_cmd;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

>>> sv/overlapping_pulse_port_driver_top.sv
// An accepted req beat passes the front register and the queue; the back end
// then applies its mode, checks the live pulses (not when the port is disabled)
// and sends the rsp beat once the result register is free. The back end takes
// a new item only when it is through with the last; its walk ages one ring slot
// per cycle, at most 4.
// Reset (synchronous, active high) clears ring head, pulse count, background,
// port value, pending flag, registers and queue; slot contents stay undefined.
`default_nettype none
module overlapping_pulse_port_driver_top import opd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // tdata: pulse_or_mask [7:0], now [39:8]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: mode [1:0]
   input  wire logic [1:0]             req_tuser,
   // result channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // tdata: port_value [7:0], port_write [8], pending_pulses [11:9], zero [15:12]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // configuration write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers; writes are taken every cycle
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PULSE_DURATION: cfg_in.pulse_duration = csr_data[DUR_BITS-1:0];
            CSR_PORT_ENABLE:    cfg_in.port_enable    = csr_data[0];
            default:            cfg_in = cfg_ff;   // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // front end -> queue -> back end
   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_cmd, q_cmd;
   rsp_type rsp;

   opd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mode   (req_tuser),
      .in_value  (req_tdata[DATA_BITS-1:0]),
      .in_now    (req_tdata[DATA_BITS+NOW_BITS-1:DATA_BITS]),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd)
   );

   opd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   opd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // result beat packing
   assign rsp_tdata = {4'b0000, rsp.pending_pulses, rsp.port_write, rsp.port_value};

endmodule
`default_nettype wire

>>> sv/opd_checker.sv
// Port-level checks of the pulse port driver, bound to the top level.
// Depends on opd_pkg and overlapping_pulse_port_driver_top.
`default_nettype none
module opd_checker import opd_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // the pulse count never exceeds the ring size
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:9] <= 3'(PULSE_SLOTS))
      else $error("pending_pulses out of range");

   // pad bits of the result beat stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == 4'b0000)
      else $error("rsp pad bits not zero");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

endmodule

bind overlapping_pulse_port_driver_top opd_checker u_opd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

>>> sim/overlapping_pulse_port_driver_top_test.sv
// Self-checking testbench for overlapping_pulse_port_driver_top: directed and random
// port commands, predicted in-bench and compared beat by beat. Depends on opd_pkg and the top.
`timescale 1ns / 100ps
module overlapping_pulse_port_driver_top_test;
   import opd_pkg::*;

   localparam int QUIET_LIMIT = 5000;   // cycles with no beat on any channel
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int SETTLE      = 20;     // longer than the worst-case req-to-rsp latency

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = CMD_REFRESH;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_PULSE_DURATION;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   overlapping_pulse_port_driver_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // In-bench copy of the port state, advanced once per accepted req beat
   // ---------------------------------------------------------------------
   logic [DATA_BITS-1:0] slot_val  [PULSE_SLOTS];
   logic [TIME_BITS-1:0] slot_time [PULSE_SLOTS];
   int                   head_idx;
   int                   live_cnt;
   logic [DATA_BITS-1:0] bg_byte;
   logic [DATA_BITS-1:0] driven_byte;
   logic                 pulse_waiting;    // started pulse not yet recorded
   logic [DUR_BITS-1:0]  dur_cfg;
   logic                 enable_cfg;

   rsp_type port_writes_due[$];            // expected rsp beats, oldest first
   int      error_count;

   // Idle percentages per side; zero gives back-to-back traffic.
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_ask;                           // bumped by a test to request a hold-off

   initial begin
      foreach (slot_val[i]) begin
         slot_val[i]  = '0;
         slot_time[i] = '0;
      end
      head_idx      = 0;
      live_cnt      = 0;
      bg_byte       = '0;
      driven_byte   = '0;
      pulse_waiting = 1'b0;
      dur_cfg       = '0;
      enable_cfg    = 1'b0;
      error_count   = 0;
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      hold_ask      = 0;
   end

   // Applies one command and returns the port update it causes.
   function automatic rsp_type next_port_state(input cmd_kind_type kind,
                                               input logic [DATA_BITS-1:0] bits,
                                               input logic [TIME_BITS-1:0] stamp);
      rsp_type              r;
      logic [DATA_BITS-1:0] drive;
      logic [TIME_BITS-1:0] age;
      int                   pos;
      int                   left;
      logic                 stop;
      r = '0;
      case (kind)
         CMD_PULSE: begin
            slot_val[head_idx] = bits;
            pulse_waiting = 1'b1;
         end
         CMD_SET:  bg_byte = bg_byte | bits;
         CMD_MASK: bg_byte = bg_byte & bits;
         default: ;
      endcase
      // disabled port: mode applied, nothing refreshed
      if (!enable_cfg) begin
         r.port_value = driven_byte;
         return r;
      end
      drive = pulse_waiting ? (bg_byte | slot_val[head_idx]) : bg_byte;
      // walk newest first; first expired pulse drops itself and all older ones
      pos  = head_idx;
      stop = 1'b0;
      for (left = live_cnt; left > 0 && !stop; left--) begin
         pos = (pos + PULSE_SLOTS - 1) % PULSE_SLOTS;
         age = stamp - slot_time[pos];
         if (age < {1'b0, dur_cfg}) begin
            drive = drive | slot_val[pos];
         end else begin
            live_cnt = live_cnt - left;
            stop = 1'b1;
         end
      end
      if (drive != driven_byte) begin
         driven_byte  = drive;
         r.port_write = 1'b1;
      end
      if (pulse_waiting) begin
         slot_time[head_idx] = stamp;
         head_idx = (head_idx + 1) % PULSE_SLOTS;
         if (live_cnt < PULSE_SLOTS) live_cnt++;
         pulse_waiting = 1'b0;
      end
      r.port_value     = driven_byte;
      r.pending_pulses = live_cnt[PEND_BITS-1:0];
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // Offers one req beat; valid stays high into the next call when no gap.
   task automatic send_cmd(input cmd_kind_type kind, input logic [DATA_BITS-1:0] bits,
                           input logic [TIME_BITS-1:0] stamp);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {stamp, bits};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      port_writes_due.push_back(next_port_state(kind, bits, stamp));
   endtask

   // Sender pause: wait until every expected beat is back.
   task automatic drain_port;
      req_tvalid <= 1'b0;
      while (port_writes_due.size() != 0) @(posedge clock);
   endtask

   // Writes both registers, valid held high across the two beats.
   task automatic configure(input logic [DUR_BITS-1:0] dur, input logic en);
      drain_port();
      csr_index <= CSR_PULSE_DURATION;
      csr_data  <= {1'b0, dur};
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      dur_cfg = dur;
      csr_index <= CSR_PORT_ENABLE;
      csr_data  <= {{(CSR_DATA_W-1){1'b0}}, en};
      do @(posedge clock); while (!csr_ready);
      enable_cfg = en;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: checks each rsp beat, then picks next tready
   // ---------------------------------------------------------------------
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;
   int rsp_gap;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (port_writes_due.size() == 0) begin
               $error("rsp beat with nothing expected: tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = port_writes_due.pop_front();
               if (rsp_tdata[7:0] !== want.port_value) begin
                  $error("port_value: expected %h, got %h", want.port_value, rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tdata[8] !== want.port_write) begin
                  $error("port_write: expected %b, got %b", want.port_write, rsp_tdata[8]);
                  error_count++;
               end
               if (rsp_tdata[11:9] !== want.pending_pulses) begin
                  $error("pending_pulses: expected %0d, got %0d",
                         want.pending_pulses, rsp_tdata[11:9]);
                  error_count++;
               end
            end
         end
         // long hold-off on request, else random stalls
         if (hold_ask != hold_seen) begin
            hold_seen  <= hold_ask;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_gap = pick_gap(rsp_idle_pct);
            if (rsp_gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left <= rsp_gap - 1;
            end
         end
      end
   end

   // Watchdog: ends the run when no channel moves a beat for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** overlapping_pulse_port_driver_top: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Port disabled: background and pulse still taken, port holds, pulse
   // stays pending until the first refresh after enabling.
   task automatic test_port_disabled;
      configure(31'd20, 1'b0);
      send_cmd(CMD_SET,     8'h0F, 32'd100);
      send_cmd(CMD_MASK,    8'h3C, 32'd101);
      send_cmd(CMD_PULSE,   8'hC0, 32'd102);
      send_cmd(CMD_REFRESH, 8'h00, 32'd103);
      configure(31'd20, 1'b1);
      send_cmd(CMD_REFRESH, 8'h00, 32'd104);   // pending pulse shows now
      send_cmd(CMD_REFRESH, 8'h00, 32'd130);   // and has aged out
   endtask

   // Zero duration: pulse visible only on its own beat.
   task automatic test_zero_duration;
      configure(31'd0, 1'b1);
      send_cmd(CMD_PULSE,   8'h81, 32'd200);
      send_cmd(CMD_REFRESH, 8'h55, 32'd200);
   endtask

   // Ring overflow across the timestamp wrap, maximum duration, byte extremes.
   task automatic test_ring_full;
      configure(31'h7FFF_FFFF, 1'b1);
      send_cmd(CMD_MASK,  8'h00, 32'hFFFF_FFFB);
      send_cmd(CMD_PULSE, 8'h01, 32'hFFFF_FFFC);
      send_cmd(CMD_PULSE, 8'h02, 32'hFFFF_FFFD);
      send_cmd(CMD_PULSE, 8'h04, 32'hFFFF_FFFE);
      send_cmd(CMD_PULSE, 8'h08, 32'hFFFF_FFFF);
      send_cmd(CMD_PULSE, 8'h10, 32'h0000_0000);  // overwrites oldest slot
      // newest pulse is 2^32-1 old here: expired, drops every older one
      send_cmd(CMD_REFRESH, 8'hFF, 32'hFFFF_FFFF);
      send_cmd(CMD_SET,     8'hFF, 32'h0000_0000);
      send_cmd(CMD_MASK,    8'h00, 32'h8000_0000);
   endtask

   // Newer pulse alive while the older one has expired.
   task automatic test_expiry;
      configure(31'd10, 1'b1);
      send_cmd(CMD_PULSE,   8'h01, 32'd1000);
      send_cmd(CMD_PULSE,   8'h02, 32'd1005);
      send_cmd(CMD_REFRESH, 8'h00, 32'd1012);
      send_cmd(CMD_REFRESH, 8'h00, 32'd1020);
   endtask

   // One random command with a timestamp that mostly creeps forward.
   task automatic random_cmd(input int step_max, inout logic [TIME_BITS-1:0] stamp);
      int                   pick;
      cmd_kind_type         kind;
      logic [DATA_BITS-1:0] bits;
      if ($urandom_range(19) == 0)
         stamp = $urandom;               // arbitrary jump, may run backwards
      else
         stamp = stamp + $urandom_range(0, step_max);
      pick = $urandom_range(99);
      bits = DATA_BITS'($urandom_range(255));
      if (pick < 35)      kind = CMD_REFRESH;
      else if (pick < 65) kind = CMD_PULSE;
      else if (pick < 80) kind = CMD_SET;
      else begin
         kind = CMD_MASK;
         // mostly clear one bit so the background does not collapse to zero
         if ($urandom_range(3) != 0) bits = ~(8'h01 << $urandom_range(7));
      end
      send_cmd(kind, bits, stamp);
   endtask

   // Receiver holds off while the sender keeps offering: queue fills, req stalls.
   task automatic test_hold_off;
      logic [TIME_BITS-1:0] stamp;
      configure(31'd50, 1'b1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      stamp = 32'd5000;
      hold_ask = hold_ask + 1;
      repeat (40) random_cmd(20, stamp);
      drain_port();
   endtask

   task automatic run_phase(input logic [DUR_BITS-1:0] dur, input logic en, input int count,
                            input int req_pct, input int rsp_pct);
      logic [TIME_BITS-1:0] stamp;
      int                   step_max;
      configure(dur, en);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      stamp = $urandom;
      if (dur == 0)        step_max = 4;
      else if (dur < 3000) step_max = dur * 2 / 3 + 1;
      else                 step_max = 2000;
      repeat (count) random_cmd(step_max, stamp);
   endtask

   task automatic test_random_traffic;
      run_phase(31'd0, 1'b1, 300, 0, 0);
      run_phase(31'd1, 1'b1, 250, 30, 30);
      run_phase(31'($urandom_range(2, 50)), 1'b1, 300, 60, 20);
      run_phase(31'($urandom_range(51, 5000)), 1'b1, 300, 20, 60);
      run_phase(31'h7FFF_FFFF, 1'b1, 250, 30, 0);
      run_phase(31'($urandom_range(2, 40)), 1'b0, 120, 10, 10);
      run_phase(31'($urandom & 32'h7FFF_FFFF), 1'b1, 300, 40, 40);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_port_disabled();
      test_zero_duration();
      test_ring_full();
      test_expiry();
      test_hold_off();
      test_random_traffic();
      drain_port();
      repeat (SETTLE) @(posedge clock);   // catch any stray rsp beat
      if (error_count == 0)
         $display("** overlapping_pulse_port_driver_top: PASSED **");
      else
         $display("** overlapping_pulse_port_driver_top: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
sv/opd_pkg.sv
sv/opd_front.sv
sv/opd_queue.sv
sv/opd_back.sv
sv/overlapping_pulse_port_driver_top.sv
sv/opd_checker.sv
sim/overlapping_pulse_port_driver_top_test.sv
